@@ design/bdp_pkg.sv @@
// Shared types and constants for the box downsample pyramid.
// Used by the level cell, the line RAM wiring, the top level and the checker.
package bdp_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_LEVELS = 4;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 12;
    localparam int W_W     = $clog2(MAX_WIDTH + 1);
    localparam int SZ_W    = (W_W > CFG_W) ? W_W : CFG_W;
    localparam int LEVEL_W = $clog2(MAX_LEVELS + 1);
    localparam int LINE_AW = $clog2(MAX_WIDTH) - 1;
    localparam int LINE_DW = PIX_W + 1;
    localparam int IDX_W   = 2;

    localparam logic [CFG_W-1:0] DEF_SRC_W = CFG_W'(640);
    localparam logic [CFG_W-1:0] DEF_SRC_H = CFG_W'(480);
    localparam logic [CFG_W-1:0] DEF_TGT_W = CFG_W'(160);
    localparam logic [CFG_W-1:0] DEF_TGT_H = CFG_W'(120);

    typedef enum logic [IDX_W-1:0] {
        CFG_SRC_W = 2'd0,
        CFG_SRC_H = 2'd1,
        CFG_TGT_W = 2'd2,
        CFG_TGT_H = 2'd3
    } t_cfg_idx;

    // Word handed from one level cell to the next. With fs set, w and h carry the frame
    // sizes at this level's scale and rem the count of levels still to run.
    typedef struct packed {
        logic               fs;
        logic               has_pix;
        logic               emit;
        logic [PIX_W-1:0]   pix;
        logic               row_end;
        logic               frame_end;
        logic [W_W-1:0]     w;
        logic [CFG_W-1:0]   h;
        logic [LEVEL_W-1:0] rem;
    } t_bdp_word;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [LINE_AW-1:0] addr;
        logic [LINE_DW-1:0] wdata;
    } t_line_req;

endpackage

@@ design/bdp_line_ram.sv @@
// Single-port line buffer holding horizontal pair sums of one level.
// Registered read data; no package dependency.
module bdp_line_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 9
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [DATA_W-1:0]                        i_wdata,
    output logic [DATA_W-1:0]                        o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/bdp_cell.sv @@
// One pyramid level: 2x2 box average over a raster at this level's scale.
// Depends on bdp_pkg; pair sums of even rows live in an external line RAM.
module bdp_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  bdp_pkg::t_bdp_word            i_word,
    output bdp_pkg::t_bdp_word            o_word,
    output bdp_pkg::t_line_req            o_line_req,
    input  logic [bdp_pkg::LINE_DW-1:0]   i_line_rdata
);
    import bdp_pkg::*;

    // frame sizes and position at this level
    logic [W_W-1:0]     r_w, cur_w;
    logic [CFG_W-1:0]   r_h, cur_h;
    logic [LEVEL_W-1:0] r_rem, cur_rem;
    logic [W_W-1:0]     r_col, cur_col, n_col, col_inc;
    logic [CFG_W-1:0]   r_row, cur_row, n_row;
    logic [PIX_W-1:0]   r_held, cur_held, n_held;

    // stage A: pair formed, line RAM accessed
    t_bdp_word          r_a, n_a;
    logic               r_a_made, n_a_made;
    logic               r_a_last, n_a_last;
    logic [LINE_DW-1:0] r_a_pair, n_a_pair;
    logic               r_a_re, n_a_re;
    logic               r_a_fe, n_a_fe;

    // stage B: vertical sum done
    t_bdp_word          r_b, n_b;

    logic               work, pair_ok, wrap;
    logic [W_W-1:0]     x_next;
    logic [CFG_W-1:0]   y_next;
    logic [LINE_DW:0]   box_sum;

    always_comb begin
        cur_w    = i_word.fs ? i_word.w   : r_w;
        cur_h    = i_word.fs ? i_word.h   : r_h;
        cur_rem  = i_word.fs ? i_word.rem : r_rem;
        cur_col  = i_word.fs ? '0 : r_col;
        cur_row  = i_word.fs ? '0 : r_row;
        cur_held = i_word.fs ? '0 : r_held;

        work    = i_word.has_pix && (cur_rem != '0) && (cur_row < cur_h) && (cur_w != '0);
        pair_ok = cur_col[0] && (cur_col < {cur_w[W_W-1:1], 1'b0});
        col_inc = cur_col + W_W'(1);
        wrap    = (col_inc == cur_w);

        n_col  = cur_col;
        n_row  = cur_row;
        n_held = cur_held;
        if (work) begin
            n_col = wrap ? '0 : col_inc;
            if (wrap) begin
                n_row = cur_row + CFG_W'(1);
            end
            if (!cur_col[0]) begin
                n_held = i_word.pix;
            end
        end

        n_a_pair = {1'b0, cur_held} + {1'b0, i_word.pix};
        n_a_made = work && pair_ok && cur_row[0];
        n_a_last = (cur_rem == LEVEL_W'(1));
        x_next   = (cur_col >> 1) + W_W'(1);
        y_next   = (cur_row >> 1) + CFG_W'(1);
        n_a_re   = (x_next == (cur_w >> 1));
        n_a_fe   = n_a_re && (y_next == (cur_h >> 1));

        o_line_req.we    = i_adv && work && pair_ok && !cur_row[0];
        o_line_req.re    = i_adv && n_a_made;
        o_line_req.addr  = cur_col[LINE_AW:1];
        o_line_req.wdata = n_a_pair;

        n_a         = i_word;
        n_a.has_pix = 1'b0;
        n_a.w       = i_word.w >> 1;
        n_a.h       = i_word.h >> 1;
        n_a.rem     = (i_word.rem == '0) ? '0 : i_word.rem - LEVEL_W'(1);
    end

    always_comb begin
        box_sum = {1'b0, i_line_rdata} + {1'b0, r_a_pair};
        n_b     = r_a;
        if (r_a_made) begin
            n_b.pix = box_sum[LINE_DW:2];
            if (r_a_last) begin
                n_b.emit      = 1'b1;
                n_b.row_end   = r_a_re;
                n_b.frame_end = r_a_fe;
            end else begin
                n_b.has_pix = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem    <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_held   <= '0;
            r_a      <= '0;
            r_a_made <= 1'b0;
            r_b      <= '0;
        end else if (i_adv) begin
            r_rem    <= cur_rem;
            r_col    <= n_col;
            r_row    <= n_row;
            r_held   <= n_held;
            r_a      <= n_a;
            r_a_made <= n_a_made;
            r_b      <= n_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_w      <= cur_w;
            r_h      <= cur_h;
            r_a_last <= n_a_last;
            r_a_pair <= n_a_pair;
            r_a_re   <= n_a_re;
            r_a_fe   <= n_a_fe;
        end
    end

    assign o_word = r_b;

endmodule

@@ design/box_downsample_pyramid.sv @@
// Box downsample pyramid: halves an 8-bit grayscale raster per level by 2x2 averaging.
// Depends on bdp_pkg, bdp_cell and bdp_line_ram.
//
// Takes one pixel word per clock with no gaps of its own; each pyramid level is one
// cell of two register stages, and every pixel taken passes through all MAX_LEVELS
// cells to the output register, whatever the number of active levels. The input side
// stops only when a finished word reaches the end of the cell chain while the output
// register still holds a word that has not been taken. Frame sizes and the level
// count are taken from the registers when a word with frame_start is accepted;
// before the first frame_start after reset the block runs one level at 640x480.
// Each level keeps one line of horizontal pair sums in its own line RAM.
module box_downsample_pyramid (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [bdp_pkg::PIX_W-1:0]   i_in_pixel,
    input  logic                        i_frame_start,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [bdp_pkg::PIX_W-1:0]   o_out_pixel,
    output logic                        o_row_end,
    output logic                        o_frame_end,
    input  logic                        i_cfg_we,
    input  logic [bdp_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [bdp_pkg::CFG_W-1:0]   i_cfg_data
);
    import bdp_pkg::*;

    logic [CFG_W-1:0]   r_src_w, r_src_h, r_tgt_w, r_tgt_h;
    logic               r_first;
    logic               r_out_valid;
    logic [PIX_W-1:0]   r_out_pixel;
    logic               r_out_re, r_out_fe;

    logic               w_adv, in_acc, go;
    logic [W_W-1:0]     w0;
    logic [LEVEL_W-1:0] n_lev;
    t_bdp_word          w_chain [MAX_LEVELS+1];
    t_line_req          w_req   [MAX_LEVELS];
    logic [LINE_DW-1:0] w_rdata [MAX_LEVELS];
    t_bdp_word          end_word;

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= DEF_SRC_W;
            r_src_h <= DEF_SRC_H;
            r_tgt_w <= DEF_TGT_W;
            r_tgt_h <= DEF_TGT_H;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SRC_W: r_src_w <= i_cfg_data;
                CFG_SRC_H: r_src_h <= i_cfg_data;
                CFG_TGT_W: r_tgt_w <= i_cfg_data;
                CFG_TGT_H: r_tgt_h <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // level count: keep halving while both halved sizes exceed the target
    always_comb begin
        w0    = (SZ_W'(r_src_w) > SZ_W'(MAX_WIDTH)) ? W_W'(MAX_WIDTH) : W_W'(r_src_w);
        n_lev = LEVEL_W'(1);
        go    = 1'b1;
        for (int j = 1; j < MAX_LEVELS; j++) begin
            go = go && (SZ_W'(w0 >> j) > SZ_W'(r_tgt_w))
                    && (SZ_W'(r_src_h >> j) > SZ_W'(r_tgt_h));
            if (go) begin
                n_lev = n_lev + LEVEL_W'(1);
            end
        end
    end

    assign end_word   = w_chain[MAX_LEVELS];
    assign w_adv      = !r_out_valid || i_out_ready || !end_word.emit;
    assign o_in_ready = w_adv;
    assign in_acc     = i_in_valid && w_adv;

    always_comb begin
        w_chain[0]           = '0;
        w_chain[0].has_pix   = in_acc;
        w_chain[0].pix       = i_in_pixel;
        w_chain[0].fs        = in_acc && (i_frame_start || r_first);
        if (i_frame_start) begin
            w_chain[0].w   = w0;
            w_chain[0].h   = r_src_h;
            w_chain[0].rem = n_lev;
        end else begin
            w_chain[0].w   = W_W'(DEF_SRC_W);
            w_chain[0].h   = DEF_SRC_H;
            w_chain[0].rem = LEVEL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (in_acc) begin
            r_first <= 1'b0;
        end
    end

    for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_level
        localparam int LD  = ((MAX_WIDTH >> (k + 1)) > 0) ? (MAX_WIDTH >> (k + 1)) : 1;
        localparam int LAW = (LD > 1) ? $clog2(LD) : 1;

        bdp_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_adv        (w_adv),
            .i_word       (w_chain[k]),
            .o_word       (w_chain[k+1]),
            .o_line_req   (w_req[k]),
            .i_line_rdata (w_rdata[k])
        );

        bdp_line_ram #(
            .DEPTH  (LD),
            .DATA_W (LINE_DW)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (w_req[k].we),
            .i_re    (w_req[k].re),
            .i_addr  (w_req[k].addr[LAW-1:0]),
            .i_wdata (w_req[k].wdata),
            .o_rdata (w_rdata[k])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && end_word.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && end_word.emit) begin
            r_out_pixel <= end_word.pix;
            r_out_re    <= end_word.row_end;
            r_out_fe    <= end_word.frame_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_pixel = r_out_pixel;
    assign o_row_end   = r_out_re;
    assign o_frame_end = r_out_fe;

endmodule

@@ design/bdp_checker.sv @@
// Port-level checks for the box downsample pyramid, bound to the top level.
// Depends on bdp_pkg for widths.
module bdp_port_checks (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [bdp_pkg::PIX_W-1:0]   o_out_pixel,
    input logic                        o_row_end,
    input logic                        o_frame_end
);
    // a held output word keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_pixel)
            && $stable(o_row_end) && $stable(o_frame_end))
        else $error("output word changed while stalled");

    // last pixel of a frame is also last of its row
    a_fe_re: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_frame_end || o_row_end)
        else $error("frame end without row end");

    // input side stalls only behind a blocked output word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled with output free");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind box_downsample_pyramid bdp_port_checks u_bdp_port_checks (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_pixel   (o_out_pixel),
    .o_row_end     (o_row_end),
    .o_frame_end   (o_frame_end)
);
